>>> hw/rtl/hostmode_response_deframer_assert.svh
// Assertion macros shared by the deframer files.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef HOSTMODE_RESPONSE_DEFRAMER_ASSERT_SVH
`define HOSTMODE_RESPONSE_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

>>> hw/rtl/hrd_pkg.sv
package hrd_pkg;

  localparam logic [7:0] B_SOH      = 8'h01;
  localparam logic [7:0] B_DLE      = 8'h10;
  localparam logic [7:0] B_ETB      = 8'h17;
  localparam logic [7:0] CMD_DATA   = 8'h30;
  localparam logic [7:0] CMD_STATUS = 8'h4f;
  localparam logic [7:0] CMD_ECHO   = 8'h40;
  localparam logic [7:0] CMD_ACK    = 8'h5f;
  localparam logic [7:0] IRS_RESET  = 8'd100;

  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_O = 8'h4f;
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_R = 8'h52;

  localparam logic [15:0] HEAD_XX = {CH_X, CH_X};
  localparam logic [15:0] HEAD_OV = {CH_O, CH_V};
  localparam logic [15:0] HEAD_OP = {CH_O, CH_P};

  // Payload position that holds the mode character of an OP frame.
  localparam logic [2:0] MODE_POS = 3'd5;
  localparam logic [2:0] POS_MAX  = 3'd7;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_NOSTART = 2'd2;
  localparam logic [1:0] KIND_ABORT  = 2'd3;

  localparam logic [1:0] OPM_NONE    = 2'd0;
  localparam logic [1:0] OPM_ISS     = 2'd1;
  localparam logic [1:0] OPM_IRS     = 2'd2;
  localparam logic [1:0] OPM_UNKNOWN = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_CMD  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timeout;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] command;
    logic [7:0] data;
    logic       data_ack;
    logic       echoed_command;
    logic       changeover_retry;
    logic [1:0] opmode;
  } result_t;

  typedef struct packed {
    logic idle;
  } status_t;

endpackage

>>> hw/rtl/hrd_if.sv
interface hrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timeout;

  modport source (output valid, output rx_byte, output timeout, input ready);
  modport sink   (input valid, input rx_byte, input timeout, output ready);
endinterface

interface hrd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] command;
  logic [7:0] data;
  logic       data_ack;
  logic       echoed_command;
  logic       changeover_retry;
  logic [1:0] opmode;

  modport source (output valid, output kind, output command, output data,
                  output data_ack, output echoed_command, output changeover_retry,
                  output opmode, input ready);
  modport sink   (input valid, input kind, input command, input data,
                  input data_ack, input echoed_command, input changeover_retry,
                  input opmode, output ready);
endinterface

>>> hw/rtl/hrd_in_stage.sv
module hrd_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  hrd_in_if.sink           in_ch,
  input  logic             adv,
  output logic             s1_valid,
  output hrd_pkg::in_item_t s1_item
);
  import hrd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // The stage takes a beat whenever it is empty or is being drained this cycle.
  assign in_ch.ready = !valid_r || adv;
  assign valid_nxt   = in_ch.ready ? in_ch.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= '{rx_byte: in_ch.rx_byte, timeout: in_ch.timeout};
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;
endmodule

>>> hw/rtl/hrd_parser.sv
module hrd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              s1_valid,
  input  hrd_pkg::in_item_t s1_item,
  input  logic              adv,
  output logic              res_valid,
  output hrd_pkg::result_t  res,
  output hrd_pkg::status_t  status
);
  import hrd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic        esc_r, esc_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [15:0] head_r, head_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [7:0]  wait_r, wait_nxt;
  logic [7:0]  cfg_r;

  logic        take;
  logic [7:0]  rx;
  logic [7:0]  cnt_load, cnt_dec, cnt_end;
  logic        end_retry;
  logic [1:0]  end_mode;
  logic        is_status;

  assign take      = s1_valid && adv;
  assign rx        = s1_item.rx_byte;
  assign is_status = (cmd_r == CMD_STATUS);

  // Frame-end summary, computed from the frame registers.
  always_comb begin
    cnt_load  = (head_r == HEAD_OV) ? cfg_r : wait_r;
    cnt_dec   = (cnt_load != 8'd0) ? cnt_load - 8'd1 : 8'd0;
    end_retry = (cnt_dec == 8'd1);
    cnt_end   = end_retry ? 8'd0 : cnt_dec;
    end_mode  = OPM_NONE;
    if (head_r == HEAD_OP) begin
      if (mode_r == CH_S) begin
        end_mode = OPM_ISS;
      end else if (mode_r == CH_R) begin
        end_mode = OPM_IRS;
        cnt_end  = 8'd0;
      end else begin
        end_mode = OPM_UNKNOWN;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    esc_nxt   = esc_r;
    pos_nxt   = pos_r;
    head_nxt  = head_r;
    mode_nxt  = mode_r;
    wait_nxt  = wait_r;
    res_valid = 1'b0;
    res       = '0;
    if (take) begin
      if (s1_item.timeout) begin
        if (phase_r == PH_CMD || phase_r == PH_BODY) begin
          res_valid   = 1'b1;
          res.kind    = KIND_ABORT;
          res.command = (phase_r == PH_BODY) ? cmd_r : 8'h00;
          esc_nxt     = 1'b0;
          pos_nxt     = 3'd0;
          head_nxt    = 16'd0;
          mode_nxt    = 8'd0;
        end
        phase_nxt = PH_IDLE;
      end else begin
        unique case (phase_r)
          PH_CMD: begin
            cmd_nxt  = rx;
            esc_nxt  = 1'b0;
            pos_nxt  = 3'd0;
            head_nxt = 16'd0;
            mode_nxt = 8'd0;
            if (rx == B_ETB) begin
              // ETB as the command byte: an empty frame with no special command.
              res_valid   = 1'b1;
              res.kind    = KIND_END;
              res.command = rx;
              phase_nxt   = PH_IDLE;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            if (!esc_r && rx == B_DLE) begin
              esc_nxt = 1'b1;
            end else if (!esc_r && rx == B_ETB) begin
              res_valid            = 1'b1;
              res.kind             = KIND_END;
              res.command          = cmd_r;
              res.data_ack         = (cmd_r == CMD_ACK) && (head_r == HEAD_XX);
              res.echoed_command   = (cmd_r == CMD_ECHO);
              res.changeover_retry = is_status && end_retry;
              res.opmode           = is_status ? end_mode : OPM_NONE;
              if (is_status) begin
                wait_nxt = cnt_end;
              end
              phase_nxt = PH_IDLE;
              esc_nxt   = 1'b0;
              pos_nxt   = 3'd0;
              head_nxt  = 16'd0;
              mode_nxt  = 8'd0;
            end else begin
              esc_nxt = 1'b0;
              if (pos_r == 3'd0) begin
                head_nxt[15:8] = rx;
              end else if (pos_r == 3'd1) begin
                head_nxt[7:0] = rx;
              end else if (pos_r == MODE_POS) begin
                mode_nxt = rx;
              end
              if (pos_r != POS_MAX) begin
                pos_nxt = pos_r + 3'd1;
              end
              if (cmd_r == CMD_DATA) begin
                res_valid   = 1'b1;
                res.kind    = KIND_BYTE;
                res.command = cmd_r;
                res.data    = rx;
              end
            end
          end
          default: begin
            if (rx == B_SOH) begin
              phase_nxt = PH_CMD;
              cmd_nxt   = 8'h00;
              esc_nxt   = 1'b0;
              pos_nxt   = 3'd0;
              head_nxt  = 16'd0;
              mode_nxt  = 8'd0;
            end else begin
              phase_nxt = PH_IDLE;
              res_valid = 1'b1;
              res.kind  = KIND_NOSTART;
              res.data  = rx;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= 8'h00;
      esc_r   <= 1'b0;
      pos_r   <= 3'd0;
      head_r  <= 16'd0;
      mode_r  <= 8'd0;
      wait_r  <= 8'd0;
      cfg_r   <= IRS_RESET;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      esc_r   <= esc_nxt;
      pos_r   <= pos_nxt;
      head_r  <= head_nxt;
      mode_r  <= mode_nxt;
      wait_r  <= wait_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  assign status.idle = (phase_r != PH_CMD) && (phase_r != PH_BODY);
endmodule

>>> hw/rtl/hrd_out_stage.sv
module hrd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  hrd_pkg::result_t res,
  output logic             adv,
  hrd_out_if.source        out_ch
);
  import hrd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // The register moves whenever it is empty or its beat is taken this cycle.
  assign adv       = !valid_r || out_ch.ready;
  assign valid_nxt = adv ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.kind             = res_r.kind;
  assign out_ch.command          = res_r.command;
  assign out_ch.data             = res_r.data;
  assign out_ch.data_ack         = res_r.data_ack;
  assign out_ch.echoed_command   = res_r.echoed_command;
  assign out_ch.changeover_retry = res_r.changeover_retry;
  assign out_ch.opmode           = res_r.opmode;
endmodule

>>> hw/rtl/hostmode_response_deframer.sv
// Host-mode response deframer. Feed it the modem's receive bytes, one beat per
// byte, or a beat with timeout set when the receive timer runs out. It finds
// SOH-command-payload-ETB frames, removes DLE escapes, passes the payload bytes
// of data frames (command 0x30) out as single beats, and gives one summary beat
// at every frame end: data acknowledge, echoed command, the opmode reported by
// an OP status frame, and a changeover resend request once the countdown armed
// by an OV reply has run down. A stray byte outside a frame gives a missing
// start beat; a timeout inside a frame drops the frame and gives an abort beat.
// The block takes one beat every clock cycle while the consumer takes its
// results. Each beat passes an input register and then a result register,
// and its result is presented from the result register; one parser state
// update per cycle sets that rate.
// cfg_wdata written with cfg_we sets the countdown length (reset value 100)
// and must only be written while no beat is in flight.
`include "hostmode_response_deframer_assert.svh"

module hostmode_response_deframer (
  input  logic       clk,
  input  logic       rst_n,
  hrd_in_if.sink     in_ch,
  hrd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import hrd_pkg::*;

  logic     s1_valid;
  in_item_t s1_item;
  logic     adv;
  logic     res_valid;
  result_t  res;
  status_t  status;
  logic     out_not_end;
  logic     out_nostart;
  logic     end_flags_clear;

  // Input register: holds the accepted beat until the parser can use it.
  hrd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Parser: frame state, escape handling and the frame-end summary.
  hrd_parser u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  // Result register: parts the parser from a stalled consumer.
  hrd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .adv       (adv),
    .out_ch    (out_ch)
  );

  assign out_not_end     = out_ch.valid && (out_ch.kind != KIND_END);
  assign out_nostart     = out_ch.valid && (out_ch.kind == KIND_NOSTART);
  assign end_flags_clear = !out_ch.data_ack && !out_ch.echoed_command &&
                           !out_ch.changeover_retry && (out_ch.opmode == OPM_NONE);

  // Frame-end flags only ever appear on frame-end beats.
  `HRD_ASSERT_IMPL(a_flags_only_at_end, out_not_end, end_flags_clear)
  // A missing start byte never carries a command.
  `HRD_ASSERT_IMPL(a_nostart_no_cmd, out_nostart, out_ch.command == 8'h00)
  // A full input register that cannot drain must stall the input side.
  `HRD_ASSERT_IMPL(a_in_stall, s1_valid && !adv, !in_ch.ready)
  // A consumed timeout always leaves the parser waiting for a start byte.
  `HRD_ASSERT_NEXT(a_timeout_idle, s1_valid && adv && s1_item.timeout, status.idle)
endmodule

>>> tb/hostmode_response_deframer_checker.sv
`timescale 1ns / 100ps

// Watches the input, result and register ports of the deframer. It predicts
// each result beat from the accepted input beats and compares it with what
// the block delivers.
module hostmode_response_deframer_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  logic             in_timeout,
  input  logic             out_valid,
  input  logic             out_ready,
  input  hrd_pkg::result_t out_beat,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  output int               mismatch_count,
  output int               pending_results
);
  import hrd_pkg::*;

  // Predicted parser state.
  phase_t      frame_phase;
  logic [7:0]  cur_cmd;
  logic        esc_pending;
  logic [2:0]  pay_pos;
  logic [15:0] head_pair;
  logic [7:0]  mode_byte;
  logic [7:0]  irs_countdown;
  logic [7:0]  retry_frames;

  result_t expected_beats[$];
  result_t want_beat;
  result_t fresh_beat;
  int      errors = 0;

  function automatic void drop_frame_state();
    esc_pending = 1'b0;
    pay_pos     = '0;
    head_pair   = '0;
    mode_byte   = '0;
  endfunction

  function automatic result_t end_of_frame();
    result_t r;
    r         = '0;
    r.kind    = KIND_END;
    r.command = cur_cmd;
    if (cur_cmd == CMD_ACK && head_pair == HEAD_XX) r.data_ack = 1'b1;
    if (cur_cmd == CMD_ECHO) r.echoed_command = 1'b1;
    if (cur_cmd == CMD_STATUS) begin
      if (head_pair == HEAD_OV) irs_countdown = retry_frames;
      if (irs_countdown != 0) irs_countdown = irs_countdown - 8'd1;
      if (irs_countdown == 8'd1) begin
        r.changeover_retry = 1'b1;
        irs_countdown      = '0;
      end
      if (head_pair == HEAD_OP) begin
        if (mode_byte == CH_S) begin
          r.opmode = OPM_ISS;
        end else if (mode_byte == CH_R) begin
          r.opmode      = OPM_IRS;
          irs_countdown = '0;
        end else begin
          r.opmode = OPM_UNKNOWN;
        end
      end
    end
    frame_phase = PH_IDLE;
    drop_frame_state();
    return r;
  endfunction

  function automatic bit take_payload(input logic [7:0] b, output result_t r);
    r = '0;
    case (pay_pos)
      3'd0:     head_pair[15:8] = b;
      3'd1:     head_pair[7:0]  = b;
      MODE_POS: mode_byte       = b;
      default:  ;
    endcase
    if (pay_pos != POS_MAX) pay_pos = pay_pos + 3'd1;
    if (cur_cmd == CMD_DATA) begin
      r.kind    = KIND_BYTE;
      r.command = cur_cmd;
      r.data    = b;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the predicted state by one input beat; returns 1 with the
  // expected result when the beat produces one.
  function automatic bit deframe_beat(input logic [7:0] b, input logic tmo,
                                      output result_t r);
    r = '0;
    if (tmo) begin
      if (frame_phase == PH_IDLE) return 1'b0;
      r.kind      = KIND_ABORT;
      r.command   = (frame_phase == PH_BODY) ? cur_cmd : 8'h00;
      frame_phase = PH_IDLE;
      drop_frame_state();
      return 1'b1;
    end
    case (frame_phase)
      PH_CMD: begin
        cur_cmd = b;
        drop_frame_state();
        if (b == B_ETB) begin
          r = end_of_frame();
          return 1'b1;
        end
        frame_phase = PH_BODY;
        return 1'b0;
      end
      PH_BODY: begin
        if (esc_pending) begin
          esc_pending = 1'b0;
          return take_payload(b, r);
        end
        if (b == B_DLE) begin
          esc_pending = 1'b1;
          return 1'b0;
        end
        if (b == B_ETB) begin
          r = end_of_frame();
          return 1'b1;
        end
        return take_payload(b, r);
      end
      default: begin
        if (b == B_SOH) begin
          frame_phase = PH_CMD;
          cur_cmd     = '0;
          drop_frame_state();
          return 1'b0;
        end
        r.kind = KIND_NOSTART;
        r.data = b;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_phase   = PH_IDLE;
      cur_cmd       = '0;
      irs_countdown = '0;
      retry_frames  = IRS_RESET;
      drop_frame_state();
      expected_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result beat kind=%0d cmd=%02h data=%02h",
                     $time, out_beat.kind, out_beat.command, out_beat.data);
        end else begin
          want_beat = expected_beats.pop_front();
          if (out_beat !== want_beat) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch expected kind=%0d cmd=%02h data=%02h %s%0b%s%0b%s%0b%s%0d",
                       $time, want_beat.kind, want_beat.command, want_beat.data,
                       "ack=", want_beat.data_ack, " echo=", want_beat.echoed_command,
                       " retry=", want_beat.changeover_retry, " opmode=",
                       want_beat.opmode);
            if (errors <= 10)
              $display("%0t:          actual   kind=%0d cmd=%02h data=%02h %s%0b%s%0b%s%0b%s%0d",
                       $time, out_beat.kind, out_beat.command, out_beat.data,
                       "ack=", out_beat.data_ack, " echo=", out_beat.echoed_command,
                       " retry=", out_beat.changeover_retry, " opmode=",
                       out_beat.opmode);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (deframe_beat(in_rx_byte, in_timeout, fresh_beat))
          expected_beats.push_back(fresh_beat);
      end
      if (cfg_we) retry_frames = cfg_wdata;
    end
    mismatch_count  <= errors;
    pending_results <= expected_beats.size();
  end

endmodule

>>> tb/hostmode_response_deframer_tb.sv
`timescale 1ns / 100ps

// Top of the deframer testbench. It makes the clock, the reset and all the
// stimulus, drives the receive side's ready, and gives the verdict. The
// checker beside the block does all prediction and comparison.
module hostmode_response_deframer_tb;
  import hrd_pkg::*;

  // Longest stretch without any handshake before the run is declared hung.
  // The slowest legal stretch is a sender gap plus a receiver stall plus the
  // settle time before a register write.
  localparam int STALL_LIMIT = 1000;
  // Cycles given to beats that produce no result before the block counts as
  // idle; a beat passes the input register and then the parser.
  localparam int SETTLE_CYCLES = 8;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  hrd_in_if  in_ch ();
  hrd_out_if out_ch ();

  int mismatch_count;
  int pending_results;

  hostmode_response_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  hostmode_response_deframer_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_rx_byte      (in_ch.rx_byte),
    .in_timeout      (in_ch.timeout),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_beat        ({out_ch.kind, out_ch.command, out_ch.data, out_ch.data_ack,
                       out_ch.echoed_command, out_ch.changeover_retry,
                       out_ch.opmode}),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver switches between three habits: long stretches of steady
  // ready, a random flicker, and runs of stalls.
  initial begin
    int ready_run;
    int habit;
    ready_run = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ready_run == 0) begin
        habit = $urandom_range(0, 9);
        if (habit < 4) begin
          out_ch.ready <= 1'b1;
          ready_run = $urandom_range(10, 60);
        end else if (habit < 8) begin
          out_ch.ready <= 1'($urandom_range(0, 1));
          ready_run = $urandom_range(1, 3);
        end else begin
          out_ch.ready <= 1'b0;
          ready_run = $urandom_range(1, 12);
        end
      end else begin
        ready_run--;
      end
    end
  end

  // The watchdog ends the run when no handshake of any kind happens for too
  // long, which also catches results that never arrive.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("hostmode_response_deframer_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int          beats_sent = 0;
  int          burst_left = 0;
  logic [7:0]  body_q[$];

  // Offers one input beat and returns at the edge that accepts it. The sender
  // works in bursts; between bursts valid drops for a random gap, sometimes
  // none at all so that long unbroken streams occur as well.
  task automatic push_beat(input logic [7:0] b, input logic tmo);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 20);
      else gap = $urandom_range(1, 4);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.timeout <= tmo;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    beats_sent++;
  endtask

  // Picks a payload byte with a strong lean toward the bytes that matter to
  // the parser: the framing bytes and the letters of the status replies.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 19))
      0:       return B_DLE;
      1:       return B_ETB;
      2:       return B_SOH;
      3:       return CH_X;
      4:       return CH_O;
      5:       return CH_P;
      6:       return CH_V;
      7:       return CH_S;
      8:       return CH_R;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_bytes(input int n);
    repeat (n) body_q.push_back(pick_byte());
  endtask

  // Sends SOH, the command and the payload in body_q, then ETB, or a timeout
  // in place of ETB when the frame is to be cut off. DLE and ETB in the
  // payload are always escaped; other bytes now and then, which is legal and
  // must not shift the payload positions.
  task automatic send_frame(input logic [7:0] cmd, input bit cut);
    push_beat(B_SOH, 1'b0);
    push_beat(cmd, 1'b0);
    foreach (body_q[i]) begin
      if (body_q[i] == B_DLE || body_q[i] == B_ETB || $urandom_range(0, 7) == 0)
        push_beat(B_DLE, 1'b0);
      push_beat(body_q[i], 1'b0);
    end
    if (cut) push_beat(8'($urandom_range(0, 255)), 1'b1);
    else push_beat(B_ETB, 1'b0);
  endtask

  // Most of the random traffic is well formed frames of every command the
  // block knows, with random content; the rest is stray bytes, timeouts and
  // frames broken off early.
  task automatic send_random_frame();
    int         pick;
    int         variant;
    bit         cut;
    logic [7:0] cmd;
    body_q.delete();
    pick = $urandom_range(0, 99);
    cut  = ($urandom_range(0, 9) == 0);
    if (pick < 72) begin
      if (pick < 25) begin
        cmd = CMD_DATA;
        add_bytes($urandom_range(0, 8));
      end else if (pick < 47) begin
        cmd     = CMD_STATUS;
        variant = $urandom_range(0, 4);
        if (variant == 0) begin
          body_q = {CH_O, CH_V};
          add_bytes($urandom_range(0, 3));
        end else if (variant == 1) begin
          // Mode character lands at payload position five.
          body_q = {CH_O, CH_P};
          add_bytes(3);
          case ($urandom_range(0, 2))
            0:       body_q.push_back(CH_S);
            1:       body_q.push_back(CH_R);
            default: body_q.push_back(pick_byte());
          endcase
          add_bytes($urandom_range(0, 2));
        end else if (variant == 3) begin
          // An OP reply too short to carry its mode character.
          body_q = {CH_O, CH_P};
          add_bytes($urandom_range(0, 3));
        end else if (variant == 4) begin
          add_bytes($urandom_range(0, 7));
        end
      end else if (pick < 57) begin
        cmd = CMD_ACK;
        if ($urandom_range(0, 2) != 0) body_q = {CH_X, CH_X};
        else body_q = {CH_X, pick_byte()};
        add_bytes($urandom_range(0, 3));
      end else if (pick < 64) begin
        cmd = CMD_ECHO;
        add_bytes($urandom_range(0, 4));
      end else begin
        cmd = 8'($urandom_range(0, 255));
        add_bytes($urandom_range(0, 6));
      end
      send_frame(cmd, cut);
    end else if (pick < 80) begin
      // A start byte followed at once by a timeout or by ETB as the command.
      push_beat(B_SOH, 1'b0);
      if ($urandom_range(0, 1) == 0) push_beat(8'($urandom_range(0, 255)), 1'b1);
      else push_beat(B_ETB, 1'b0);
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 3)) push_beat(pick_byte(), 1'b0);
    end else begin
      push_beat(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = beats_sent + n;
    while (beats_sent < target) send_random_frame();
  endtask

  // Waits until every expected result has arrived and then gives beats that
  // produce no result time to leave the block.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_retry_frames(input logic [7:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 8'h00;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    in_ch.timeout <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats, run with the countdown length at its reset value.
    // Stray bytes at both ends of the range outside a frame, then a timeout
    // outside a frame, which must give nothing.
    push_beat(8'h00, 1'b0);
    push_beat(8'hff, 1'b0);
    push_beat(8'hff, 1'b1);
    // A timeout right after the start byte aborts with command zero.
    push_beat(B_SOH, 1'b0);
    push_beat(8'h00, 1'b1);
    // ETB in the command slot closes an empty frame at once.
    push_beat(B_SOH, 1'b0);
    push_beat(B_ETB, 1'b0);
    // A data frame carrying an escaped ETB and an escaped DLE; the DLE DLE
    // pair right before the final ETB must not swallow it.
    body_q = {B_ETB, B_DLE};
    send_frame(CMD_DATA, 1'b0);
    // A data acknowledge and an echoed command.
    body_q = {CH_X, CH_X};
    send_frame(CMD_ACK, 1'b0);
    body_q.delete();
    send_frame(CMD_ECHO, 1'b0);
    // DLE as the command byte is literal; the frame is then timed out.
    body_q = {8'hff};
    send_frame(B_DLE, 1'b1);
    // An OP reply without its mode character reports an unknown mode.
    body_q = {CH_O, CH_P};
    send_frame(CMD_STATUS, 1'b0);

    // Shortest countdown: an OV reply requests the resend at its own end.
    set_retry_frames(8'd2);
    run_random(80);

    // Longest countdown: one OV reply, then status frames until the resend
    // request comes out on the last of them.
    set_retry_frames(8'd255);
    body_q = {CH_O, CH_V};
    send_frame(CMD_STATUS, 1'b0);
    body_q.delete();
    repeat (253) send_frame(CMD_STATUS, 1'b0);

    set_retry_frames(8'd5);
    run_random(40);
    set_retry_frames(8'($urandom_range(3, 16)));
    run_random(40);
    set_retry_frames(8'($urandom_range(2, 255)));
    run_random(40);

    drain();
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("hostmode_response_deframer_tb: PASS");
    end else begin
      $display("hostmode_response_deframer_tb: FAIL");
    end
    $finish;
  end

endmodule
